@@ design/tlpw_pkg.sv @@
// shared constants and types for the two-level page walk core
package tlpw_pkg;

    localparam int DIR_ENTRIES_DEF   = 1024;
    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int MEM_BYTES_DEF     = 1048576;
    localparam int FRAME_BYTES       = 4096;

    localparam int IDX_W       = 10;
    localparam int OFFSET_W    = 12;
    localparam int FRAME_W     = 8;
    localparam int SLOT_W      = 8;
    localparam int SLOT_COUNT  = 256;
    localparam int PTR9_W      = 9;
    localparam int PADDR_W     = 20;
    localparam int CNT_W       = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_STORE = 1'b1;

    // one classified access word handed from front to back
    typedef struct packed {
        logic                kind;
        logic [IDX_W-1:0]    dir_index;
        logic [IDX_W-1:0]    table_index;
        logic [OFFSET_W-1:0] offset;
        logic [7:0]          write_data;
    } tlpw_req_t;

endpackage

@@ design/tlpw_front.sv @@
// front end: accepts access words and reduces the address indexes
module tlpw_front
    import tlpw_pkg::*;
#(
    parameter int DIR_ENTRIES   = DIR_ENTRIES_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        enable,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        kind,
    input  logic [31:0] virtual_address,
    input  logic [7:0]  write_data,
    output logic        push,
    output tlpw_req_t   push_data,
    input  logic        full
);

    localparam int RECIP_SHIFT = 21;
    localparam int PROD_W      = 28;
    localparam int QUO_W       = PROD_W - RECIP_SHIFT;
    localparam int REM_W       = 12;
    localparam int DIR_RECIP   = (2 ** RECIP_SHIFT) / DIR_ENTRIES;
    localparam int TBL_RECIP   = (2 ** RECIP_SHIFT) / TABLE_ENTRIES;

    // quotient is low by at most one, so one correction step is enough
    function automatic logic [IDX_W-1:0] wrap_index(
        input logic [IDX_W-1:0] x,
        input logic [QUO_W-1:0] q,
        input logic [REM_W-1:0] n
    );
        logic [REM_W-1:0] rem;
        rem = REM_W'(x) - REM_W'(q) * n;
        if (rem >= n) begin
            rem = rem - n;
        end
        return rem[IDX_W-1:0];
    endfunction

    logic [IDX_W-1:0]    di_raw;
    logic [IDX_W-1:0]    ti_raw;
    logic [PROD_W-1:0]   di_prod;
    logic [PROD_W-1:0]   ti_prod;

    logic                s1_valid_reg;
    logic                s1_kind_reg;
    logic [7:0]          s1_wdata_reg;
    logic [OFFSET_W-1:0] s1_offset_reg;
    logic [IDX_W-1:0]    s1_di_reg;
    logic [IDX_W-1:0]    s1_ti_reg;
    logic [QUO_W-1:0]    s1_di_quo_reg;
    logic [QUO_W-1:0]    s1_ti_quo_reg;

    assign di_raw  = virtual_address[31:22];
    assign ti_raw  = virtual_address[21:12];
    assign di_prod = PROD_W'(di_raw) * PROD_W'(DIR_RECIP);
    assign ti_prod = PROD_W'(ti_raw) * PROD_W'(TBL_RECIP);

    assign push       = s1_valid_reg && !full;
    assign item_ready = enable && (!s1_valid_reg || !full);

    always_comb
    begin
        push_data.kind        = s1_kind_reg;
        push_data.dir_index   = wrap_index(s1_di_reg, s1_di_quo_reg, REM_W'(DIR_ENTRIES));
        push_data.table_index = wrap_index(s1_ti_reg, s1_ti_quo_reg, REM_W'(TABLE_ENTRIES));
        push_data.offset      = s1_offset_reg;
        push_data.write_data  = s1_wdata_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_kind_reg   <= 1'b0;
            s1_wdata_reg  <= '0;
            s1_offset_reg <= '0;
            s1_di_reg     <= '0;
            s1_ti_reg     <= '0;
            s1_di_quo_reg <= '0;
            s1_ti_quo_reg <= '0;
        end
        else if (item_ready)
        begin
            s1_valid_reg <= item_valid;
            if (item_valid)
            begin
                s1_kind_reg   <= kind;
                s1_wdata_reg  <= write_data;
                s1_offset_reg <= virtual_address[OFFSET_W-1:0];
                s1_di_reg     <= di_raw;
                s1_ti_reg     <= ti_raw;
                s1_di_quo_reg <= di_prod[PROD_W-1:RECIP_SHIFT];
                s1_ti_quo_reg <= ti_prod[PROD_W-1:RECIP_SHIFT];
            end
        end
    end

endmodule

@@ design/tlpw_queue.sv @@
// short fifo between the front end and the walk engine
module tlpw_queue
    import tlpw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  tlpw_req_t push_data,
    output logic      full,
    input  logic      pop,
    output tlpw_req_t pop_data,
    output logic      not_empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_Q_W = $clog2(QUEUE_DEPTH + 1);

    tlpw_req_t          entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_Q_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full      = (count_reg == CNT_Q_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ design/tlpw_back.sv @@
// walk engine: directory, table and byte memories, allocation and counters
module tlpw_back
    import tlpw_pkg::*;
#(
    parameter int DIR_ENTRIES   = DIR_ENTRIES_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int MEM_BYTES     = MEM_BYTES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    output logic               accepting,
    input  logic               q_valid,
    input  tlpw_req_t          q_data,
    output logic               q_pop,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [7:0]         read_data,
    output logic               hit,
    output logic               table_allocated,
    output logic               page_mapped,
    output logic               out_of_frames,
    output logic [PADDR_W-1:0] physical_address,
    output logic [CNT_W-1:0]   hit_total,
    output logic [CNT_W-1:0]   miss_total
);

    localparam int DIW = $clog2(DIR_ENTRIES);
    localparam int TIW = $clog2(TABLE_ENTRIES);
    localparam int TAW = SLOT_W + TIW;
    localparam int TBL_DEPTH = SLOT_COUNT * (2 ** TIW);
    localparam int MEM_AW = $clog2(MEM_BYTES);
    localparam int EXT_W = MEM_AW + PADDR_W;
    localparam int FRAME_LIMIT_RAW = MEM_BYTES / FRAME_BYTES;
    localparam int FRAME_LIMIT =
        (FRAME_LIMIT_RAW < SLOT_COUNT) ? FRAME_LIMIT_RAW : SLOT_COUNT;
    localparam int CLR_A = (MEM_BYTES > TBL_DEPTH) ? MEM_BYTES : TBL_DEPTH;
    localparam int CLR_LEN = (CLR_A > DIR_ENTRIES) ? CLR_A : DIR_ENTRIES;
    localparam int CLR_W = $clog2(CLR_LEN + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIR,
        ST_TBL,
        ST_MEM
    } state_t;

    // memories
    logic [SLOT_W:0]    dir_mem  [DIR_ENTRIES];
    logic [FRAME_W-1:0] tbl_mem  [TBL_DEPTH];
    logic [7:0]         byte_mem [MEM_BYTES];
    logic [SLOT_W:0]    dir_rdata_reg;
    logic [FRAME_W-1:0] tbl_rdata_reg;
    logic [7:0]         mem_rdata_reg;

    // control and result registers
    state_t             state_reg, state_next;
    logic [CLR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    tlpw_req_t          req_reg, req_next;
    logic               dir_ok_reg, dir_ok_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [PTR9_W-1:0]  next_slot_reg, next_slot_next;
    logic [PTR9_W-1:0]  next_frame_reg, next_frame_next;
    logic [CNT_W-1:0]   hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0]   miss_cnt_reg, miss_cnt_next;
    logic               pend_hit_reg, pend_hit_next;
    logic               pend_talloc_reg, pend_talloc_next;
    logic               pend_map_reg, pend_map_next;
    logic               pend_fault_reg, pend_fault_next;
    logic               pend_load_reg, pend_load_next;
    logic [PADDR_W-1:0] pend_paddr_reg, pend_paddr_next;
    logic               result_valid_reg, result_valid_next;
    logic [7:0]         read_data_reg, read_data_next;
    logic               hit_reg, hit_next;
    logic               talloc_reg, talloc_next;
    logic               mapped_reg, mapped_next;
    logic               fault_reg, fault_next;
    logic [PADDR_W-1:0] paddr_reg, paddr_next;
    logic [CNT_W-1:0]   hit_total_reg, hit_total_next;
    logic [CNT_W-1:0]   miss_total_reg, miss_total_next;

    // walk datapath
    logic               clearing;
    logic               can_load;
    logic [SLOT_W-1:0]  walk_slot;
    logic [TAW-1:0]     tbl_rd_addr;
    logic [FRAME_W-1:0] frame_old;
    logic               walk_hit;
    logic               walk_fault;
    logic               walk_map;
    logic               walk_talloc;
    logic [FRAME_W-1:0] walk_frame;
    logic [PADDR_W-1:0] walk_paddr;
    logic [EXT_W-1:0]   paddr_ext;
    logic               in_range;
    logic               mem_access;

    // memory write ports
    logic               dir_we;
    logic [DIW-1:0]     dir_waddr;
    logic [SLOT_W:0]    dir_wdata;
    logic               tbl_we;
    logic [TAW-1:0]     tbl_waddr;
    logic [FRAME_W-1:0] tbl_wdata;
    logic               mem_we;
    logic               mem_re;
    logic [MEM_AW-1:0]  mem_addr;
    logic [7:0]         mem_wdata;

    assign clearing  = (state_reg == ST_CLEAR);
    assign accepting = !clearing;
    assign can_load  = !result_valid_reg || result_ready;
    assign q_pop     = q_valid &&
                       ((state_reg == ST_IDLE) || ((state_reg == ST_MEM) && can_load));

    assign walk_slot   = dir_rdata_reg[SLOT_W] ? dir_rdata_reg[SLOT_W-1:0]
                                               : next_slot_reg[SLOT_W-1:0];
    assign tbl_rd_addr = {walk_slot, req_reg.table_index[TIW-1:0]};

    always_comb
    begin
        frame_old   = dir_ok_reg ? tbl_rdata_reg : '0;
        walk_hit    = dir_ok_reg && (frame_old != '0);
        walk_fault  = !walk_hit &&
                      ((next_frame_reg >= PTR9_W'(FRAME_LIMIT)) ||
                       (!dir_ok_reg && (next_slot_reg >= PTR9_W'(SLOT_COUNT))));
        walk_map    = !walk_hit && !walk_fault;
        walk_talloc = walk_map && !dir_ok_reg;
        walk_frame  = walk_map ? next_frame_reg[FRAME_W-1:0] : frame_old;
        walk_paddr  = walk_fault ? '0 : {walk_frame, req_reg.offset};
        paddr_ext   = {{MEM_AW{1'b0}}, walk_paddr};
        in_range    = paddr_ext < EXT_W'(MEM_BYTES);
        mem_access  = (state_reg == ST_TBL) && !walk_fault && in_range;
    end

    // write port selection, clearing pass first
    always_comb
    begin
        dir_we    = 1'b0;
        dir_waddr = req_reg.dir_index[DIW-1:0];
        dir_wdata = {1'b1, slot_reg};
        tbl_we    = 1'b0;
        tbl_waddr = {slot_reg, req_reg.table_index[TIW-1:0]};
        tbl_wdata = next_frame_reg[FRAME_W-1:0];
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = paddr_ext[MEM_AW-1:0];
        mem_wdata = req_reg.write_data;
        if (clearing)
        begin
            dir_we    = clr_cnt_reg < CLR_W'(DIR_ENTRIES);
            dir_waddr = clr_cnt_reg[DIW-1:0];
            dir_wdata = '0;
            tbl_we    = clr_cnt_reg < CLR_W'(TBL_DEPTH);
            tbl_waddr = clr_cnt_reg[TAW-1:0];
            tbl_wdata = '0;
            mem_we    = clr_cnt_reg < CLR_W'(MEM_BYTES);
            mem_addr  = clr_cnt_reg[MEM_AW-1:0];
            mem_wdata = '0;
        end
        else if (state_reg == ST_TBL)
        begin
            dir_we = walk_talloc;
            tbl_we = walk_map;
            mem_we = mem_access && (req_reg.kind == KIND_STORE);
            mem_re = mem_access && (req_reg.kind == KIND_LOAD);
        end
    end

    always_ff @(posedge clk)
    begin
        if (dir_we)
        begin
            dir_mem[dir_waddr] <= dir_wdata;
        end
        if (q_pop)
        begin
            dir_rdata_reg <= dir_mem[q_data.dir_index[DIW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        if (state_reg == ST_DIR)
        begin
            tbl_rdata_reg <= tbl_mem[tbl_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            byte_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= byte_mem[mem_addr];
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        req_next          = req_reg;
        dir_ok_next       = dir_ok_reg;
        slot_next         = slot_reg;
        next_slot_next    = next_slot_reg;
        next_frame_next   = next_frame_reg;
        hit_cnt_next      = hit_cnt_reg;
        miss_cnt_next     = miss_cnt_reg;
        pend_hit_next     = pend_hit_reg;
        pend_talloc_next  = pend_talloc_reg;
        pend_map_next     = pend_map_reg;
        pend_fault_next   = pend_fault_reg;
        pend_load_next    = pend_load_reg;
        pend_paddr_next   = pend_paddr_reg;
        result_valid_next = result_valid_reg && !result_ready;
        read_data_next    = read_data_reg;
        hit_next          = hit_reg;
        talloc_next       = talloc_reg;
        mapped_next       = mapped_reg;
        fault_next        = fault_reg;
        paddr_next        = paddr_reg;
        hit_total_next    = hit_total_reg;
        miss_total_next   = miss_total_reg;

        if (q_pop)
        begin
            req_next = q_data;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_W'(CLR_LEN - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_DIR;
                end
            end
            ST_DIR:
            begin
                dir_ok_next = dir_rdata_reg[SLOT_W];
                slot_next   = walk_slot;
                state_next  = ST_TBL;
            end
            ST_TBL:
            begin
                if (walk_hit)
                begin
                    hit_cnt_next = (hit_cnt_reg == CNT_MAX) ? hit_cnt_reg
                                                            : hit_cnt_reg + 1'b1;
                end
                else
                begin
                    miss_cnt_next = (miss_cnt_reg == CNT_MAX) ? miss_cnt_reg
                                                              : miss_cnt_reg + 1'b1;
                end
                if (walk_talloc)
                begin
                    next_slot_next = next_slot_reg + 1'b1;
                end
                if (walk_map)
                begin
                    next_frame_next = next_frame_reg + 1'b1;
                end
                pend_hit_next    = walk_hit;
                pend_talloc_next = walk_talloc;
                pend_map_next    = walk_map;
                pend_fault_next  = walk_fault;
                pend_load_next   = mem_re;
                pend_paddr_next  = walk_paddr;
                state_next       = ST_MEM;
            end
            ST_MEM:
            begin
                if (can_load)
                begin
                    result_valid_next = 1'b1;
                    read_data_next    = pend_load_reg ? mem_rdata_reg : '0;
                    hit_next          = pend_hit_reg;
                    talloc_next       = pend_talloc_reg;
                    mapped_next       = pend_map_reg;
                    fault_next        = pend_fault_reg;
                    paddr_next        = pend_paddr_reg;
                    hit_total_next    = hit_cnt_reg;
                    miss_total_next   = miss_cnt_reg;
                    state_next        = q_valid ? ST_DIR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            req_reg          <= '0;
            dir_ok_reg       <= 1'b0;
            slot_reg         <= '0;
            next_slot_reg    <= '0;
            next_frame_reg   <= PTR9_W'(1);
            hit_cnt_reg      <= '0;
            miss_cnt_reg     <= '0;
            pend_hit_reg     <= 1'b0;
            pend_talloc_reg  <= 1'b0;
            pend_map_reg     <= 1'b0;
            pend_fault_reg   <= 1'b0;
            pend_load_reg    <= 1'b0;
            pend_paddr_reg   <= '0;
            result_valid_reg <= 1'b0;
            read_data_reg    <= '0;
            hit_reg          <= 1'b0;
            talloc_reg       <= 1'b0;
            mapped_reg       <= 1'b0;
            fault_reg        <= 1'b0;
            paddr_reg        <= '0;
            hit_total_reg    <= '0;
            miss_total_reg   <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_cnt_reg      <= clr_cnt_next;
            req_reg          <= req_next;
            dir_ok_reg       <= dir_ok_next;
            slot_reg         <= slot_next;
            next_slot_reg    <= next_slot_next;
            next_frame_reg   <= next_frame_next;
            hit_cnt_reg      <= hit_cnt_next;
            miss_cnt_reg     <= miss_cnt_next;
            pend_hit_reg     <= pend_hit_next;
            pend_talloc_reg  <= pend_talloc_next;
            pend_map_reg     <= pend_map_next;
            pend_fault_reg   <= pend_fault_next;
            pend_load_reg    <= pend_load_next;
            pend_paddr_reg   <= pend_paddr_next;
            result_valid_reg <= result_valid_next;
            read_data_reg    <= read_data_next;
            hit_reg          <= hit_next;
            talloc_reg       <= talloc_next;
            mapped_reg       <= mapped_next;
            fault_reg        <= fault_next;
            paddr_reg        <= paddr_next;
            hit_total_reg    <= hit_total_next;
            miss_total_reg   <= miss_total_next;
        end
    end

    assign result_valid     = result_valid_reg;
    assign read_data        = read_data_reg;
    assign hit              = hit_reg;
    assign table_allocated  = talloc_reg;
    assign page_mapped      = mapped_reg;
    assign out_of_frames    = fault_reg;
    assign physical_address = paddr_reg;
    assign hit_total        = hit_total_reg;
    assign miss_total       = miss_total_reg;

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !result_valid_reg)
        else $error("result word present during clearing pass");

    a_frame_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (next_frame_reg != '0) && (next_frame_reg <= PTR9_W'(FRAME_LIMIT)))
        else $error("free frame pointer out of bounds");

    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> $onehot({hit_reg, mapped_reg, fault_reg}))
        else $error("result is not exactly one of hit, map, fault");

    a_alloc_maps: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && talloc_reg |-> mapped_reg)
        else $error("table allocated without mapping a frame");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && fault_reg |-> (paddr_reg == '0) && (read_data_reg == '0))
        else $error("fault result carries address or data");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid && !clearing)
        else $error("queue popped while empty or clearing");

endmodule

@@ design/two_level_page_walk_demand_alloc_core.sv @@
// top level of the two-level page walk core with demand allocation
// walk: each word steps through the dependent directory, table and byte memory reads
//   in the walk engine, one word at a time; a result not yet taken stalls the next walk
// reset: after rst_n rises a clearing pass over max(MEM_BYTES, 256 * 2**ceil(log2
//   TABLE_ENTRIES), DIR_ENTRIES) addresses (1048576 by default) zeroes all memories
module two_level_page_walk_demand_alloc_core
    import tlpw_pkg::*;
#(
    parameter int DIR_ENTRIES   = DIR_ENTRIES_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int MEM_BYTES     = MEM_BYTES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // access channel
    input  logic               item_valid,
    output logic               item_ready,
    input  logic               kind,
    input  logic [31:0]        virtual_address,
    input  logic [7:0]         write_data,
    // result channel
    output logic               result_valid,
    input  logic               result_ready,
    output logic [7:0]         read_data,
    output logic               hit,
    output logic               table_allocated,
    output logic               page_mapped,
    output logic               out_of_frames,
    output logic [PADDR_W-1:0] physical_address,
    output logic [CNT_W-1:0]   hit_total,
    output logic [CNT_W-1:0]   miss_total
);

    // front to queue
    logic      push;
    tlpw_req_t push_data;
    logic      full;

    // queue to back
    logic      pop;
    tlpw_req_t pop_data;
    logic      not_empty;

    // low while the back end runs its clearing pass
    logic      accepting;

    // front end registers the access word and folds the directory and table
    // indexes into range with a reciprocal multiply before the register and a correction step after it
    tlpw_front #(
        .DIR_ENTRIES   (DIR_ENTRIES),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .enable          (accepting),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .kind            (kind),
        .virtual_address (virtual_address),
        .write_data      (write_data),
        .push            (push),
        .push_data       (push_data),
        .full            (full)
    );

    // two-entry queue so the front keeps taking words while the walk is busy
    tlpw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (not_empty)
    );

    // walk engine: directory read, table read, then allocate and touch memory;
    // result goes into an output register that the next walk runs behind
    tlpw_back #(
        .DIR_ENTRIES   (DIR_ENTRIES),
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MEM_BYTES     (MEM_BYTES)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .accepting        (accepting),
        .q_valid          (not_empty),
        .q_data           (pop_data),
        .q_pop            (pop),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .read_data        (read_data),
        .hit              (hit),
        .table_allocated  (table_allocated),
        .page_mapped      (page_mapped),
        .out_of_frames    (out_of_frames),
        .physical_address (physical_address),
        .hit_total        (hit_total),
        .miss_total       (miss_total)
    );

endmodule
